// ===== design/mvsf_pkg.sv =====
// ============================================================================
// mvsf_pkg: shared types and constants for the scrolling frame store
// Request types, opcodes, controller states and the command and status
// structs that join the controller to the datapath.
// ============================================================================
package mvsf_pkg;

    localparam int DEF_VISIBLE_LINES = 480;
    localparam int DEF_TOTAL_LINES   = 525;
    localparam int DEF_VSYNC_START   = 490;
    localparam int DEF_VSYNC_END     = 492;
    localparam int DEF_LINE_BYTES    = 64;

    localparam int COORD_W     = 9;
    localparam int WORD_BITS   = 64;
    localparam int PIX_SHIFT_W = 6;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_SCROLL = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode              opcode;
        logic [COORD_W-1:0]   pixel_x;
        logic [COORD_W-1:0]   pixel_y;
        logic [COORD_W-1:0]   scroll_amount;
    } t_in_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] line_word;
        logic                 last_word;
        logic                 vsync_out;
        logic                 blank_line;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_PIX_ADDR,
        ST_PIX_READ,
        ST_PIX_WRITE,
        ST_TICK
    } t_state;

    typedef struct packed {
        logic req_load;
        logic clr_start;
        logic clr_step;
        logic red_step;
        logic pix_addr;
        logic pix_read;
        logic pix_write;
        logic tick_start;
        logic tick_issue;
        logic line_adv;
    } t_dp_cmd;

    typedef struct packed {
        logic x_in_range;
        logic d_zero;
        logic clr_last;
        logic tick_last;
        logic q_room;
    } t_dp_status;

endpackage

// ===== design/mvsf_ctrl.sv =====
// ============================================================================
// mvsf_ctrl: sequencer for the scrolling frame store
// Accepts one request at a time and steps the datapath through clearing,
// pixel read-modify-write and line read-out.
// ============================================================================
module mvsf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  mvsf_pkg::t_opcode      i_opcode,
    input  mvsf_pkg::t_dp_status   i_status,
    output logic                   o_in_stall,
    output mvsf_pkg::t_dp_cmd      o_cmd
);

    mvsf_pkg::t_state r_state;
    mvsf_pkg::t_state n_state;
    logic             accept;

    assign accept     = i_in_valid && (r_state == mvsf_pkg::ST_IDLE);
    assign o_in_stall = (r_state != mvsf_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvsf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mvsf_pkg::ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = mvsf_pkg::ST_IDLE;
                end
            end
            mvsf_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        mvsf_pkg::OP_TICK: begin
                            n_state = mvsf_pkg::ST_TICK;
                        end
                        mvsf_pkg::OP_SET, mvsf_pkg::OP_CLEAR: begin
                            if (i_status.x_in_range) begin
                                n_state = mvsf_pkg::ST_REDUCE;
                            end
                        end
                        mvsf_pkg::OP_SCROLL: begin
                            if (!i_status.d_zero) begin
                                n_state = mvsf_pkg::ST_CLEAR;
                            end
                        end
                        default: begin
                            n_state = mvsf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mvsf_pkg::ST_REDUCE: begin
                n_state = mvsf_pkg::ST_PIX_ADDR;
            end
            mvsf_pkg::ST_PIX_ADDR: begin
                n_state = mvsf_pkg::ST_PIX_READ;
            end
            mvsf_pkg::ST_PIX_READ: begin
                n_state = mvsf_pkg::ST_PIX_WRITE;
            end
            mvsf_pkg::ST_PIX_WRITE: begin
                n_state = mvsf_pkg::ST_IDLE;
            end
            mvsf_pkg::ST_TICK: begin
                if (i_status.q_room && i_status.tick_last) begin
                    n_state = mvsf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mvsf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            mvsf_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            mvsf_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.req_load = 1'b1;
                    case (i_opcode)
                        mvsf_pkg::OP_TICK: begin
                            o_cmd.tick_start = 1'b1;
                        end
                        mvsf_pkg::OP_SCROLL: begin
                            o_cmd.clr_start = 1'b1;
                        end
                        default: begin
                            o_cmd.tick_start = 1'b0;
                        end
                    endcase
                end
            end
            mvsf_pkg::ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
            end
            mvsf_pkg::ST_PIX_ADDR: begin
                o_cmd.pix_addr = 1'b1;
            end
            mvsf_pkg::ST_PIX_READ: begin
                o_cmd.pix_read = 1'b1;
            end
            mvsf_pkg::ST_PIX_WRITE: begin
                o_cmd.pix_write = 1'b1;
            end
            mvsf_pkg::ST_TICK: begin
                if (i_status.q_room) begin
                    o_cmd.tick_issue = 1'b1;
                    o_cmd.line_adv   = i_status.tick_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/mvsf_datapath.sv =====
// ============================================================================
// mvsf_datapath: frame store, line sequencer registers and output queue
// Holds the frame memory, the row reduction unit for pixel addressing,
// the clearing sweep counters and a two-entry queue for line words.
// ============================================================================
module mvsf_datapath #(
    parameter int VISIBLE_LINES = mvsf_pkg::DEF_VISIBLE_LINES,
    parameter int TOTAL_LINES   = mvsf_pkg::DEF_TOTAL_LINES,
    parameter int VSYNC_START   = mvsf_pkg::DEF_VSYNC_START,
    parameter int VSYNC_END     = mvsf_pkg::DEF_VSYNC_END,
    parameter int LINE_BYTES    = mvsf_pkg::DEF_LINE_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mvsf_pkg::t_in_req      i_in_req,
    input  mvsf_pkg::t_dp_cmd      i_cmd,
    output mvsf_pkg::t_dp_status   o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mvsf_pkg::t_out_req     o_out_req
);

    localparam int ROW_WORDS    = LINE_BYTES / 8;
    localparam int ROW_W        = (VISIBLE_LINES > 1) ? $clog2(VISIBLE_LINES) : 1;
    localparam int WORD_W       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int ADDR_W       = ROW_W + WORD_W;
    localparam int MEM_DEPTH    = VISIBLE_LINES << WORD_W;
    localparam int LINE_W       = $clog2(TOTAL_LINES);
    localparam int SUM_W        = ROW_W + 1;
    localparam int LEFT_W       = $clog2(VISIBLE_LINES + 1);
    localparam int MIN_W        = (LEFT_W > mvsf_pkg::COORD_W) ? LEFT_W : mvsf_pkg::COORD_W;
    localparam int CW           = mvsf_pkg::COORD_W;
    localparam int WB           = mvsf_pkg::WORD_BITS;
    localparam int PIX_SHIFT_LO = mvsf_pkg::PIX_SHIFT_W;
    // Reciprocal of the row count, exact for every row number below 2**CW.
    localparam int RECIP_SH     = CW + ROW_W;
    localparam int RECIP_M      = ((1 << RECIP_SH) + VISIBLE_LINES - 1) / VISIBLE_LINES;
    localparam int PROD_W       = 2 * CW + 2;

    // Frame store
    logic [WB-1:0]     r_mem [MEM_DEPTH];
    logic [WB-1:0]     r_rdata;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WB-1:0]     mem_wdata;

    // Request and line state
    mvsf_pkg::t_in_req r_req;
    logic [LINE_W-1:0] r_line;
    logic [ROW_W-1:0]  r_scroll;
    logic              r_vsync;
    logic [ROW_W-1:0]  r_next_row;
    logic              r_next_blank;

    // Sweep and word counters
    logic [ROW_W-1:0]  r_crow;
    logic [LEFT_W-1:0] r_left;
    logic [WORD_W-1:0] r_word;
    logic [ROW_W-1:0]  crow_inc;
    logic              word_last;
    logic [LEFT_W-1:0] d_clamped;

    // Row reduction for pixel addressing
    logic [CW-1:0]     r_rem;
    logic [PROD_W-1:0] red_prod;
    logic [CW-1:0]     red_quot;
    logic [CW-1:0]     red_rem;
    logic [SUM_W-1:0]  pix_sum;
    logic [ROW_W-1:0]  pix_row;
    logic [ADDR_W-1:0] r_addr;
    logic [WB-1:0]     pix_mask;

    // Line advance
    logic [LINE_W:0]   line_inc;
    logic [31:0]       line_inc_ext;
    logic [LINE_W-1:0] n_line;
    logic              n_vsync;
    logic [SUM_W-1:0]  line_sum;

    // Read tags and output queue
    logic                r_rd_pend;
    logic                r_tag_last;
    logic                r_tag_vsync;
    logic                r_tag_blank;
    mvsf_pkg::t_out_req  r_q [2];
    logic                r_qhead;
    logic [1:0]          r_qcnt;
    logic                q_push;
    logic                q_pop;
    logic                q_tail;
    logic [2:0]          q_after;
    mvsf_pkg::t_out_req  q_item;

    // ------------------------------------------------------------------
    // Status
    // ------------------------------------------------------------------
    assign word_last = (r_word == WORD_W'(ROW_WORDS - 1));
    assign crow_inc  = (r_crow == ROW_W'(VISIBLE_LINES - 1)) ? '0 : r_crow + 1'b1;

    assign o_status.x_in_range = (32'(i_in_req.pixel_x[CW-1:PIX_SHIFT_LO]) < 32'(ROW_WORDS));
    assign o_status.d_zero     = (i_in_req.scroll_amount == '0);
    assign o_status.clr_last   = word_last && (r_left == LEFT_W'(1));
    assign o_status.tick_last  = word_last;
    assign o_status.q_room     = (q_after <= 3'd1);

    assign d_clamped = (MIN_W'(i_in_req.scroll_amount) > MIN_W'(VISIBLE_LINES))
                       ? LEFT_W'(VISIBLE_LINES) : LEFT_W'(i_in_req.scroll_amount);

    // ------------------------------------------------------------------
    // Pixel row: (y mod V + scroll) mod V, the first part taken by
    // reciprocal multiplication in the reduction cycle.
    // ------------------------------------------------------------------
    assign red_prod = PROD_W'(r_req.pixel_y) * PROD_W'(RECIP_M);
    assign red_quot = CW'(red_prod >> RECIP_SH);
    assign red_rem  = CW'(PROD_W'(r_req.pixel_y)
                          - PROD_W'(red_quot) * PROD_W'(VISIBLE_LINES));
    assign pix_sum  = SUM_W'(r_rem) + SUM_W'(r_scroll);
    assign pix_row  = (pix_sum >= SUM_W'(VISIBLE_LINES))
                      ? ROW_W'(pix_sum - SUM_W'(VISIBLE_LINES)) : ROW_W'(pix_sum);
    assign pix_mask = {1'b1, {(WB-1){1'b0}}} >> r_req.pixel_x[PIX_SHIFT_LO-1:0];

    // ------------------------------------------------------------------
    // Line counter advance
    // ------------------------------------------------------------------
    assign line_inc     = {1'b0, r_line} + 1'b1;
    assign line_inc_ext = 32'(line_inc);
    assign line_sum     = SUM_W'(n_line) + SUM_W'(r_scroll);

    always_comb begin
        n_line  = LINE_W'(line_inc);
        n_vsync = r_vsync;
        if (line_inc_ext >= 32'(TOTAL_LINES)) begin
            n_line = '0;
        end else if (line_inc_ext == 32'(VSYNC_START)) begin
            n_vsync = 1'b0;
        end else if (line_inc_ext == 32'(VSYNC_END)) begin
            n_vsync = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_crow, r_word};
        mem_wdata = '0;
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.pix_write) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr;
            mem_wdata = (r_req.opcode == mvsf_pkg::OP_SET) ? (r_rdata | pix_mask)
                                                           : (r_rdata & ~pix_mask);
        end
    end

    assign mem_re    = i_cmd.pix_read || i_cmd.tick_issue;
    assign mem_raddr = i_cmd.pix_read ? r_addr : {r_next_row, r_word};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_in_req;
        end
        if (i_cmd.red_step) begin
            r_rem <= red_rem;
        end
        if (i_cmd.pix_addr) begin
            r_addr <= {pix_row, WORD_W'(r_req.pixel_x[CW-1:PIX_SHIFT_LO])};
        end
        if (i_cmd.tick_issue) begin
            r_tag_last  <= word_last;
            r_tag_vsync <= r_vsync;
            r_tag_blank <= r_next_blank;
        end
        if (q_push) begin
            r_q[q_tail] <= q_item;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= '0;
            r_scroll     <= '0;
            r_vsync      <= 1'b1;
            r_next_row   <= '0;
            r_next_blank <= 1'b0;
            r_crow       <= '0;
            r_left       <= LEFT_W'(VISIBLE_LINES);
            r_word       <= '0;
            r_rd_pend    <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.tick_issue;
            if (i_cmd.clr_start) begin
                r_crow <= r_scroll;
                r_left <= d_clamped;
                r_word <= '0;
            end else if (i_cmd.clr_step) begin
                if (word_last) begin
                    r_word <= '0;
                    r_crow <= crow_inc;
                    r_left <= r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        r_scroll <= crow_inc;
                    end
                end else begin
                    r_word <= r_word + 1'b1;
                end
            end else if (i_cmd.tick_start) begin
                r_word <= '0;
            end else if (i_cmd.tick_issue) begin
                r_word <= word_last ? '0 : r_word + 1'b1;
            end
            if (i_cmd.line_adv) begin
                r_line  <= n_line;
                r_vsync <= n_vsync;
                if (32'(n_line) < 32'(VISIBLE_LINES)) begin
                    r_next_blank <= 1'b0;
                    r_next_row   <= (line_sum >= SUM_W'(VISIBLE_LINES))
                                    ? ROW_W'(line_sum - SUM_W'(VISIBLE_LINES))
                                    : ROW_W'(line_sum);
                end else begin
                    r_next_blank <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue: read data lands in the cycle after issue; the controller
    // only issues when the queue is sure to have space for it.
    // ------------------------------------------------------------------
    assign q_push  = r_rd_pend;
    assign q_pop   = (r_qcnt != 2'd0) && !i_out_stall;
    assign q_tail  = r_qhead ^ r_qcnt[0];
    assign q_after = {1'b0, r_qcnt} + {2'b0, r_rd_pend} - {2'b0, q_pop};

    assign q_item.line_word  = r_tag_blank ? '0 : r_rdata;
    assign q_item.last_word  = r_tag_last;
    assign q_item.vsync_out  = r_tag_vsync;
    assign q_item.blank_line = r_tag_blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qhead <= 1'b0;
            r_qcnt  <= 2'd0;
        end else begin
            r_qhead <= r_qhead ^ q_pop;
            r_qcnt  <= 2'(q_after);
        end
    end

    assign o_out_valid = (r_qcnt != 2'd0);
    assign o_out_req   = r_q[r_qhead];

endmodule

// ===== design/mono_vga_scroll_framebuffer.sv =====
// ============================================================================
// mono_vga_scroll_framebuffer: monochrome scrolling frame store with a
// VGA line sequencer
// A line tick streams one stored row as 64-bit words (zeros on a blank
// line); pixel and scroll requests modify the store.
// ============================================================================
// A line tick, once accepted, reads the row's words from the store in order,
// each passing through the read data register into the output queue; reads
// hold while the queue is full. A set or clear pixel does a row reduction and
// a read-modify-write; a scroll by d clears d rows, at most VISIBLE_LINES.
// After reset the store is cleared one word a cycle, VISIBLE_LINES *
// ROW_WORDS words in all (3840 by default), while requests are stalled.
module mono_vga_scroll_framebuffer #(
    parameter int VISIBLE_LINES = mvsf_pkg::DEF_VISIBLE_LINES,
    parameter int TOTAL_LINES   = mvsf_pkg::DEF_TOTAL_LINES,
    parameter int VSYNC_START   = mvsf_pkg::DEF_VSYNC_START,
    parameter int VSYNC_END     = mvsf_pkg::DEF_VSYNC_END,
    parameter int LINE_BYTES    = mvsf_pkg::DEF_LINE_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mvsf_pkg::t_in_req   i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mvsf_pkg::t_out_req  o_out_req
);

    mvsf_pkg::t_dp_cmd    cmd;
    mvsf_pkg::t_dp_status status;

    mvsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_req.opcode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mvsf_datapath #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES),
        .VSYNC_START   (VSYNC_START),
        .VSYNC_END     (VSYNC_END),
        .LINE_BYTES    (LINE_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== design/mvsf_checker.sv =====
// ============================================================================
// mvsf_checker: port-level checks for the scrolling frame store
// Watches the request and line word channels and the reset clearing pass.
// ============================================================================
module mvsf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mvsf_pkg::t_out_req  o_out_req
);

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("line word request dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_req))
        else $error("line word request changed while stalled");

    // Words of a blank line must carry no pixels.
    a_blank_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.blank_line |-> o_out_req.line_word == '0)
        else $error("blank line carries pixel data");

    // The store is being cleared straight after reset, so no request is taken.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("request accepted during the clearing pass");

    a_no_word_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("line word presented straight after reset");

endmodule

bind mono_vga_scroll_framebuffer mvsf_checker u_mvsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top: self-checking bench for the scrolling monochrome frame store
// A short directed sequence is followed by random requests, weighted towards
// drawing near the rows about to be scanned out. Every request is run through
// a behavioural model of the store, scroll offset and line sequencer. Each
// line word that comes back is compared field by field in arrival order.
// ============================================================================
module tb_top;

    localparam int VIS_LINES      = mvsf_pkg::DEF_VISIBLE_LINES;
    localparam int ALL_LINES      = mvsf_pkg::DEF_TOTAL_LINES;
    localparam int VS_START       = mvsf_pkg::DEF_VSYNC_START;
    localparam int VS_END         = mvsf_pkg::DEF_VSYNC_END;
    localparam int ROW_WORDS      = mvsf_pkg::DEF_LINE_BYTES / 8;
    localparam int CW             = mvsf_pkg::COORD_W;
    localparam int WB             = mvsf_pkg::WORD_BITS;
    localparam int RANDOM_ITEMS   = 450;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 40;

    class frame_scoreboard;
        logic [WB-1:0]        store [VIS_LINES][ROW_WORDS];
        int unsigned          line_no;
        int unsigned          scroll_ofs;
        int unsigned          next_row;
        bit                   vsync_lvl;
        bit                   next_blank;
        mvsf_pkg::t_out_req   line_words_due[$];
        int unsigned          error_count;
        int unsigned          word_count;

        function new();
            for (int r = 0; r < VIS_LINES; r++) begin
                for (int w = 0; w < ROW_WORDS; w++) begin
                    store[r][w] = '0;
                end
            end
            line_no     = 0;
            scroll_ofs  = 0;
            next_row    = 0;
            vsync_lvl   = 1'b1;
            next_blank  = 1'b0;
            error_count = 0;
            word_count  = 0;
        endfunction

        function int unsigned pending();
            return line_words_due.size();
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        // Applies one accepted request to the model and queues any line words.
        function void note_request(input mvsf_pkg::t_in_req r);
            mvsf_pkg::t_out_req w_exp;
            int unsigned        row;
            int unsigned        d;
            case (r.opcode)
                mvsf_pkg::OP_TICK: begin
                    for (int w = 0; w < ROW_WORDS; w++) begin
                        w_exp.line_word  = next_blank ? '0 : store[next_row][w];
                        w_exp.last_word  = (w == ROW_WORDS - 1);
                        w_exp.vsync_out  = vsync_lvl;
                        w_exp.blank_line = next_blank;
                        line_words_due.push_back(w_exp);
                    end
                    line_no++;
                    if (line_no >= ALL_LINES) begin
                        line_no = 0;
                    end else if (line_no == VS_START) begin
                        vsync_lvl = 1'b0;
                    end else if (line_no == VS_END) begin
                        vsync_lvl = 1'b1;
                    end
                    if (line_no < VIS_LINES) begin
                        next_row   = (line_no + scroll_ofs) % VIS_LINES;
                        next_blank = 1'b0;
                    end else begin
                        next_blank = 1'b1;
                    end
                end
                mvsf_pkg::OP_SET, mvsf_pkg::OP_CLEAR: begin
                    if (r.pixel_x[8:6] < ROW_WORDS) begin
                        row = (int'(r.pixel_y) + scroll_ofs) % VIS_LINES;
                        store[row][r.pixel_x[8:6]][63 - r.pixel_x[5:0]] =
                            (r.opcode == mvsf_pkg::OP_SET);
                    end
                end
                default: begin
                    d = (r.scroll_amount > VIS_LINES) ? VIS_LINES : r.scroll_amount;
                    for (int i = 0; i < d; i++) begin
                        for (int w = 0; w < ROW_WORDS; w++) begin
                            store[scroll_ofs][w] = '0;
                        end
                        scroll_ofs = (scroll_ofs + 1) % VIS_LINES;
                    end
                end
            endcase
        endfunction

        task check_result(input mvsf_pkg::t_out_req got);
            mvsf_pkg::t_out_req w_exp;
            if (line_words_due.size() == 0) begin
                report_mismatch($sformatf("line word %h arrived with none due",
                                          got.line_word));
            end else begin
                w_exp = line_words_due.pop_front();
                if (got.line_word !== w_exp.line_word)
                    report_mismatch($sformatf("word %0d line_word %h, model %h",
                                              word_count, got.line_word, w_exp.line_word));
                if (got.last_word !== w_exp.last_word)
                    report_mismatch($sformatf("word %0d last_word %b, model %b",
                                              word_count, got.last_word, w_exp.last_word));
                if (got.vsync_out !== w_exp.vsync_out)
                    report_mismatch($sformatf("word %0d vsync_out %b, model %b",
                                              word_count, got.vsync_out, w_exp.vsync_out));
                if (got.blank_line !== w_exp.blank_line)
                    report_mismatch($sformatf("word %0d blank_line %b, model %b",
                                              word_count, got.blank_line, w_exp.blank_line));
            end
            word_count++;
        endtask
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    mvsf_pkg::t_in_req  i_in_req    = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    mvsf_pkg::t_out_req o_out_req;

    frame_scoreboard sb;
    int unsigned     idle_pct     = 0;
    int unsigned     stall_pct    = 0;
    int unsigned     quiet_cycles = 0;

    mono_vga_scroll_framebuffer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always #5 i_clk = ~i_clk;

    function automatic mvsf_pkg::t_in_req make_req(input mvsf_pkg::t_opcode op,
                                                   input int unsigned x,
                                                   input int unsigned y,
                                                   input int unsigned d);
        mvsf_pkg::t_in_req r;
        r.opcode        = op;
        r.pixel_x       = CW'(x);
        r.pixel_y       = CW'(y);
        r.scroll_amount = CW'(d);
        return r;
    endfunction

    function automatic mvsf_pkg::t_in_req random_request();
        mvsf_pkg::t_in_req r;
        int unsigned       pick;
        pick            = $urandom_range(0, 99);
        r.pixel_x       = CW'($urandom_range(0, 511));
        r.pixel_y       = CW'($urandom_range(0, 511));
        r.scroll_amount = CW'($urandom_range(0, 511));
        if (pick < 50) begin
            r.opcode = mvsf_pkg::OP_TICK;
        end else if (pick < 84) begin
            r.opcode = (pick < 72) ? mvsf_pkg::OP_SET : mvsf_pkg::OP_CLEAR;
            // While a visible line is next, half the drawing lands on rows that the next few ticks will show.
            if (sb.line_no < VIS_LINES && $urandom_range(0, 1) == 1)
                r.pixel_y = CW'((sb.line_no + $urandom_range(0, 8)) % VIS_LINES);
        end else begin
            r.opcode = mvsf_pkg::OP_SCROLL;
            pick     = $urandom_range(0, 99);
            if (pick < 85)
                r.scroll_amount = CW'($urandom_range(0, 6));
            else if (pick < 95)
                r.scroll_amount = CW'($urandom_range(7, 40));
            else
                r.scroll_amount = CW'($urandom_range(470, 511));
        end
        return r;
    endfunction

    task automatic send_request(input mvsf_pkg::t_in_req r);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(r);
    endtask

    // Output side: check accepted words, then choose the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_result(o_out_req);
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        idle_pct  = 34;
        stall_pct = 53;

        // Directed: row ends and word edges, row wrap, scroll of zero, one and
        // beyond the visible height, and drawing after a scroll.
        send_request(make_req(mvsf_pkg::OP_TICK, 0, 0, 0));
        send_request(make_req(mvsf_pkg::OP_SET, 0, 1, 0));
        send_request(make_req(mvsf_pkg::OP_SET, 511, 1, 511));
        send_request(make_req(mvsf_pkg::OP_SET, 63, 1, 0));
        send_request(make_req(mvsf_pkg::OP_SET, 64, 1, 0));
        send_request(make_req(mvsf_pkg::OP_SET, 300, 2, 0));
        send_request(make_req(mvsf_pkg::OP_TICK, 511, 511, 511));
        send_request(make_req(mvsf_pkg::OP_CLEAR, 300, 2, 0));
        send_request(make_req(mvsf_pkg::OP_CLEAR, 0, 2, 0));
        send_request(make_req(mvsf_pkg::OP_SET, 5, 482, 0));
        send_request(make_req(mvsf_pkg::OP_TICK, 0, 0, 0));
        send_request(make_req(mvsf_pkg::OP_SET, 100, 511, 0));
        send_request(make_req(mvsf_pkg::OP_SCROLL, 0, 0, 0));
        send_request(make_req(mvsf_pkg::OP_SCROLL, 0, 0, 1));
        send_request(make_req(mvsf_pkg::OP_SET, 7, 479, 0));
        send_request(make_req(mvsf_pkg::OP_SET, 3, 3, 0));
        send_request(make_req(mvsf_pkg::OP_TICK, 0, 0, 0));
        send_request(make_req(mvsf_pkg::OP_TICK, 0, 0, 0));
        send_request(make_req(mvsf_pkg::OP_SCROLL, 0, 0, 511));
        send_request(make_req(mvsf_pkg::OP_SET, 200, 5, 0));
        send_request(make_req(mvsf_pkg::OP_SCROLL, 511, 511, 480));
        send_request(make_req(mvsf_pkg::OP_SET, 511, 479, 0));
        send_request(make_req(mvsf_pkg::OP_TICK, 0, 0, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                idle_pct  = 53;
                stall_pct = 34;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            send_request(random_request());
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
